// ===== src/cubic_multibrot_double_step_assert.svh =====
// Assertion helpers used by the checker file.
`ifndef CUBIC_MULTIBROT_DOUBLE_STEP_ASSERT_SVH
`define CUBIC_MULTIBROT_DOUBLE_STEP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define CMDS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define CMDS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/cmds_pkg.sv =====
package cmds_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned CNT_W         = 16;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned STEP_STAGES   = 5;
  localparam int unsigned FRAC_BITS_DEF = 28;

  localparam logic [DATA_W-1:0] ESCAPE_LIMIT_RST = 32'h4000_0000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_JULIA_MODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_JULIA_C_RE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_JULIA_C_IM   = 2'd3;

  // per-item sideband carried along the pipeline
  typedef struct packed {
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] cr;
    logic signed [DATA_W-1:0] ci;
    logic [CNT_W-1:0]         count;
    logic                     esc1;
  } side_t;

endpackage

// ===== src/cubic_multibrot_double_step.sv =====
// Channel   Direction  Handshake               Payload
// in        sink       in_valid_i/in_stall_o   z_real_i z_imag_i c_real_i c_imag_i count_in_i
// out       source     out_valid_o/out_stall_i next_real_o next_imag_o count_out_o escaped_o
// cfg       sink       cfg_we_i                cfg_idx_i cfg_data_i
//
// One item per cycle sustained while the output is not stalled; two z^3+c steps
// of five stages each (square, cube products, sums, magnitude squares,
// compare), plus the output register.
// Reset clears the valid bits and puts config at its defaults; no other wait.
// A stall freezes only the occupied stages ahead of a full one, so bubbles
// close up and items are still taken while a result waits at the output.
module cubic_multibrot_double_step #(
  parameter int unsigned FRAC_BITS = cmds_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  cfg_we_i,
  input  logic [cmds_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [cmds_pkg::DATA_W-1:0]           cfg_data_i,
  // input items
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [cmds_pkg::DATA_W-1:0]    z_real_i,
  input  logic signed [cmds_pkg::DATA_W-1:0]    z_imag_i,
  input  logic signed [cmds_pkg::DATA_W-1:0]    c_real_i,
  input  logic signed [cmds_pkg::DATA_W-1:0]    c_imag_i,
  input  logic [cmds_pkg::CNT_W-1:0]            count_in_i,
  // result items
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [cmds_pkg::DATA_W-1:0]    next_real_o,
  output logic signed [cmds_pkg::DATA_W-1:0]    next_imag_o,
  output logic [cmds_pkg::CNT_W-1:0]            count_out_o,
  output logic                                  escaped_o
);

  localparam int unsigned DW = cmds_pkg::DATA_W;
  localparam int unsigned CW = cmds_pkg::CNT_W;
  localparam int unsigned NS = cmds_pkg::STEP_STAGES;
  localparam int unsigned NP = 2 * NS;   // pipeline stages before the output

  // ---------------------------------------------------------------- config
  logic [DW-1:0]        limit_q;
  logic                 julia_q;
  logic signed [DW-1:0] jcr_q, jci_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= cmds_pkg::ESCAPE_LIMIT_RST;
      julia_q <= 1'b0;
      jcr_q   <= '0;
      jci_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cmds_pkg::CFG_ESCAPE_LIMIT: limit_q <= cfg_data_i;
        cmds_pkg::CFG_JULIA_MODE:   julia_q <= cfg_data_i[0];
        cmds_pkg::CFG_JULIA_C_RE:   jcr_q   <= cfg_data_i;
        cmds_pkg::CFG_JULIA_C_IM:   jci_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- flow control
  // rdy[k]: stage k may load this cycle (empty, or its item moves on).
  logic [NP-1:0] vld_q;
  logic [NP:0]   rdy;
  logic          out_valid_q;

  always_comb begin
    rdy[NP] = !out_valid_q || !out_stall_i;
    for (int k = NP - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_stall_o = !rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NP; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
      if (rdy[NP]) out_valid_q <= vld_q[NP-1];
    end
  end

  // ------------------------------------------------------------ sideband
  cmds_pkg::side_t side_q [NP];
  cmds_pkg::side_t side_d [NP];

  logic signed [DW-1:0] s1_re, s1_im, s2_re, s2_im;
  logic                 s1_esc, s2_esc;

  always_comb begin
    side_d[0].a     = z_real_i;
    side_d[0].b     = z_imag_i;
    // Julia mode swaps in the configured constant at entry
    side_d[0].cr    = julia_q ? jcr_q : c_real_i;
    side_d[0].ci    = julia_q ? jci_q : c_imag_i;
    side_d[0].count = count_in_i;
    side_d[0].esc1  = 1'b0;
    for (int k = 1; k < NP; k++) begin
      side_d[k] = side_q[k-1];
    end
    // first escape test joins the item as it enters the second step
    side_d[NS].esc1 = s1_esc;
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NP; k++) begin
      if (rdy[k]) side_q[k] <= side_d[k];
    end
  end

  // --------------------------------------------------------- two steps
  cmds_step #(
    .FRAC_BITS (FRAC_BITS)
  ) u_step1 (
    .clk_i   (clk_i),
    .en_i    (rdy[NS-1:0]),
    .a_i     (z_real_i),
    .b_i     (z_imag_i),
    .cr_i    (side_q[1].cr),
    .ci_i    (side_q[1].ci),
    .limit_i (limit_q),
    .re_o    (s1_re),
    .im_o    (s1_im),
    .esc_o   (s1_esc)
  );

  // always computed; dropped at the output if the first step escaped
  cmds_step #(
    .FRAC_BITS (FRAC_BITS)
  ) u_step2 (
    .clk_i   (clk_i),
    .en_i    (rdy[NP-1:NS]),
    .a_i     (s1_re),
    .b_i     (s1_im),
    .cr_i    (side_q[NS+1].cr),
    .ci_i    (side_q[NS+1].ci),
    .limit_i (limit_q),
    .re_o    (s2_re),
    .im_o    (s2_im),
    .esc_o   (s2_esc)
  );

  // ------------------------------------------------------------- output
  logic [CW:0]          cnt_sum;
  logic [CW-1:0]        cnt_d;
  logic signed [DW-1:0] nr_q, ni_q;
  logic [CW-1:0]        cnt_q;
  logic                 esc_q;

  always_comb begin
    cnt_sum = (CW+1)'(side_q[NP-1].count) + (side_q[NP-1].esc1 ? (CW+1)'(1) : (CW+1)'(2));
    cnt_d   = cnt_sum[CW] ? {CW{1'b1}} : cnt_sum[CW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NP]) begin
      nr_q  <= side_q[NP-1].esc1 ? side_q[NP-1].a : s2_re;
      ni_q  <= side_q[NP-1].esc1 ? side_q[NP-1].b : s2_im;
      cnt_q <= cnt_d;
      esc_q <= side_q[NP-1].esc1 || s2_esc;
    end
  end

  assign out_valid_o = out_valid_q;
  assign next_real_o = nr_q;
  assign next_imag_o = ni_q;
  assign count_out_o = cnt_q;
  assign escaped_o   = esc_q;

endmodule

// ===== src/cmds_step.sv =====
module cmds_step #(
  parameter int unsigned FRAC_BITS = cmds_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic [cmds_pkg::STEP_STAGES-1:0]        en_i,
  input  logic signed [cmds_pkg::DATA_W-1:0]      a_i,
  input  logic signed [cmds_pkg::DATA_W-1:0]      b_i,
  input  logic signed [cmds_pkg::DATA_W-1:0]      cr_i,   // aligned with stage 1
  input  logic signed [cmds_pkg::DATA_W-1:0]      ci_i,
  input  logic [cmds_pkg::DATA_W-1:0]             limit_i,
  output logic signed [cmds_pkg::DATA_W-1:0]      re_o,
  output logic signed [cmds_pkg::DATA_W-1:0]      im_o,
  output logic                                    esc_o
);

  localparam int unsigned DW = cmds_pkg::DATA_W;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned SW = DW + 4;

  // saturate a signed 64-bit value to the 32-bit range
  function automatic logic signed [DW-1:0] sat(input logic signed [PW-1:0] v);
    logic signed [DW-1:0] r;
    if (v[PW-1] && !(&v[PW-2:DW-1])) begin
      r = {1'b1, {(DW-1){1'b0}}};
    end else if (!v[PW-1] && (|v[PW-2:DW-1])) begin
      r = {1'b0, {(DW-1){1'b1}}};
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  // floor shift of a product, then saturate
  function automatic logic signed [DW-1:0] fx(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = p >>> FRAC_BITS;
    return sat(s);
  endfunction

  logic signed [DW-1:0] a0_q, b0_q;
  logic signed [PW-1:0] paa_q, pbb_q;
  logic signed [PW-1:0] paaa_q, pbba_q, paab_q, pbbb_q;
  logic signed [DW-1:0] re2_q, im2_q;
  logic signed [PW-1:0] rr_q, ii_q;
  logic signed [DW-1:0] re3_q, im3_q;
  logic signed [DW-1:0] re4_q, im4_q;
  logic                 esc_q;

  logic signed [DW-1:0] aa, bb, m_aaa, m_bba, m_aab, m_bbb;
  logic signed [SW-1:0] re_sum, im_sum;
  logic [PW-1:0]        mag;

  always_comb begin
    aa     = fx(paa_q);
    bb     = fx(pbb_q);
    m_aaa  = fx(paaa_q);
    m_bba  = fx(pbba_q);
    m_aab  = fx(paab_q);
    m_bbb  = fx(pbbb_q);
    re_sum = SW'(m_aaa) - ((SW'(m_bba) <<< 1) + SW'(m_bba)) + SW'(cr_i);
    im_sum = ((SW'(m_aab) <<< 1) + SW'(m_aab)) - SW'(m_bbb) + SW'(ci_i);
    mag    = ($unsigned(rr_q) + $unsigned(ii_q)) >> FRAC_BITS;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      a0_q  <= a_i;
      b0_q  <= b_i;
      paa_q <= PW'(a_i) * PW'(a_i);
      pbb_q <= PW'(b_i) * PW'(b_i);
    end
    if (en_i[1]) begin
      paaa_q <= PW'(aa) * PW'(a0_q);
      pbba_q <= PW'(bb) * PW'(a0_q);
      paab_q <= PW'(aa) * PW'(b0_q);
      pbbb_q <= PW'(bb) * PW'(b0_q);
    end
    if (en_i[2]) begin
      re2_q <= sat(PW'(re_sum));
      im2_q <= sat(PW'(im_sum));
    end
    if (en_i[3]) begin
      rr_q  <= PW'(re2_q) * PW'(re2_q);
      ii_q  <= PW'(im2_q) * PW'(im2_q);
      re3_q <= re2_q;
      im3_q <= im2_q;
    end
    if (en_i[4]) begin
      esc_q <= mag > PW'(limit_i);
      re4_q <= re3_q;
      im4_q <= im3_q;
    end
  end

  assign re_o  = re4_q;
  assign im_o  = im4_q;
  assign esc_o = esc_q;

endmodule

// ===== src/cmds_checker.sv =====
`include "cubic_multibrot_double_step_assert.svh"

module cmds_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic signed [cmds_pkg::DATA_W-1:0] next_real_o,
  input logic signed [cmds_pkg::DATA_W-1:0] next_imag_o,
  input logic [cmds_pkg::CNT_W-1:0]         count_out_o,
  input logic                               escaped_o
);

  // whole result payload, for the hold check
  logic [2*cmds_pkg::DATA_W+cmds_pkg::CNT_W:0] out_bus;

  assign out_bus = {next_real_o, next_imag_o, count_out_o, escaped_o};

  // a result holds while stalled
  `CMDS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  `CMDS_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_bus))

  // input backs up only when every stage is full and the output is stuck
  `CMDS_ASSERT_IMP(a_stall_full, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // two steps taken unless escaped after one
  `CMDS_ASSERT_IMP(a_cnt_min, clk_i, rst_ni, out_valid_o && !escaped_o, count_out_o >= 16'd2)

endmodule

bind cubic_multibrot_double_step cmds_checker u_cmds_checker (.*);
